// ===== src/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// shared constants for the point to segment distance pipeline
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS_DEF      = 16;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // result widths are fixed by the output format
  localparam int DSQ_W = 34;
  localparam int RES_W = 17;

  localparam logic [DSQ_W-1:0] DSQ_MAX = {DSQ_W{1'b1}};

endpackage

// ===== src/psd_divider.sv =====
// ----------------------------------------------------------------------------
// psd_divider
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module psd_divider #(
  parameter int LENW   = 34,
  parameter int QW     = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [LENW-1:0]   in_rem,
  input  logic [LENW-1:0]   in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo,
  output logic [SIDE_W-1:0] out_side
);
  import psd_pkg::*;

  logic              valid [0:QW];
  logic [LENW-1:0]   rem   [0:QW];
  logic [LENW-1:0]   den   [0:QW];
  logic [QW-1:0]     quo   [0:QW];
  logic [SIDE_W-1:0] side  [0:QW];

  assign valid[0] = in_valid;
  assign rem[0]   = in_rem;
  assign den[0]   = in_den;
  assign quo[0]   = '0;
  assign side[0]  = in_side;

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [LENW:0] rem_sh;
    logic          take;

    assign rem_sh = {rem[i], 1'b0};
    assign take   = rem_sh >= {1'b0, den[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      rem[i+1]  <= take ? LENW'(rem_sh - {1'b0, den[i]}) : rem_sh[LENW-1:0];
      den[i+1]  <= den[i];
      quo[i+1]  <= {quo[i][QW-2:0], take};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = valid[QW];
  assign out_quo   = quo[QW];
  assign out_side  = side[QW];

endmodule

// ===== src/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// pipelined floor square root, two radicand bits per stage
// ----------------------------------------------------------------------------
module psd_sqrt #(
  parameter int SIDE_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [psd_pkg::DSQ_W-1:0] in_x,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [psd_pkg::RES_W-1:0] out_root,
  output logic [SIDE_W-1:0]      out_side
);
  import psd_pkg::*;

  localparam int RW = RES_W + 2;

  logic              valid [0:RES_W];
  logic [DSQ_W-1:0]  x     [0:RES_W];
  logic [RW-1:0]     rem   [0:RES_W];
  logic [RES_W-1:0]  root  [0:RES_W];
  logic [SIDE_W-1:0] side  [0:RES_W];

  assign valid[0] = in_valid;
  assign x[0]     = in_x;
  assign rem[0]   = '0;
  assign root[0]  = '0;
  assign side[0]  = in_side;

  for (genvar i = 0; i < RES_W; i++) begin : g_step
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          take;

    assign rem_sh = {rem[i][RW-3:0], x[i][DSQ_W-1-2*i -: 2]};
    assign trial  = {root[i], 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[i+1] <= 1'b0;
      end else begin
        valid[i+1] <= valid[i];
      end
      x[i+1]    <= x[i];
      rem[i+1]  <= take ? rem_sh - trial : rem_sh;
      root[i+1] <= {root[i][RES_W-2:0], take};
      side[i+1] <= side[i];
    end
  end

  assign out_valid = valid[RES_W];
  assign out_root  = root[RES_W];
  assign out_side  = side[RES_W];

endmodule

// ===== src/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance
// squared distance and its floor square root from a point to a segment
// ----------------------------------------------------------------------------
// Fully pipelined: a new word may be started in every cycle and busy is always
// low. Most of the pipeline depth comes from the restoring divider (one quotient
// bit per stage) and the square root (one result bit per stage).
// Results cannot be held off, so the receiver must take done words as they come.
// A zero-length segment returns the distance to its start with degenerate set.
module point_segment_distance #(
  parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_BITS-1:0]  seg_start_x,
  input  logic signed [COORD_BITS-1:0]  seg_start_y,
  input  logic signed [COORD_BITS-1:0]  seg_end_x,
  input  logic signed [COORD_BITS-1:0]  seg_end_y,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  output logic                          done,
  output logic [psd_pkg::DSQ_W-1:0]     dist_sqr,
  output logic [psd_pkg::RES_W-1:0]     dist_res,
  output logic                          degenerate
);
  import psd_pkg::*;

  localparam int F     = PARAM_FRAC_BITS;
  localparam int DW    = COORD_BITS + 1;          // coordinate differences
  localparam int LENW  = 2 * DW;                  // squared length, unsigned
  localparam int DOTW  = 2 * DW + 1;              // dot product, signed
  localparam int TW    = F + 1;                   // clamped parameter, 1.0 = 2^F
  localparam int MW    = DW + TW;                 // |d| * t
  localparam int OW    = COORD_BITS + 3;          // offset from closest point
  localparam int SQW   = 2 * OW;
  localparam int SUMW  = SQW + 1;
  localparam int CW    = (SUMW > DSQ_W + 1) ? SUMW : DSQ_W + 1;
  localparam int SIDE_W = 4 * DW + 3;

  // no backpressure anywhere, the pipe always advances
  assign busy = 1'b0;

  // stage 1: differences
  logic                 v1;
  logic signed [DW-1:0] dx1, dy1, px1, py1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    dx1 <= DW'(seg_end_x) - DW'(seg_start_x);
    dy1 <= DW'(seg_end_y) - DW'(seg_start_y);
    px1 <= DW'(point_x) - DW'(seg_start_x);
    py1 <= DW'(point_y) - DW'(seg_start_y);
  end

  // stage 2: four products
  logic                   v2;
  logic signed [DW-1:0]   dx2, dy2, px2, py2;
  logic signed [LENW-1:0] dxx2, dyy2, pdx2, pdy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    dxx2 <= dx1 * dx1;
    dyy2 <= dy1 * dy1;
    pdx2 <= px1 * dx1;
    pdy2 <= py1 * dy1;
    dx2  <= dx1;
    dy2  <= dy1;
    px2  <= px1;
    py2  <= py1;
  end

  // stage 3: squared length, dot product
  logic                   v3;
  logic signed [DW-1:0]   dx3, dy3, px3, py3;
  logic [LENW-1:0]        len3;
  logic signed [DOTW-1:0] dot3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    len3 <= LENW'($unsigned(dxx2)) + LENW'($unsigned(dyy2));
    dot3 <= DOTW'(pdx2) + DOTW'(pdy2);
    dx3  <= dx2;
    dy3  <= dy2;
    px3  <= px2;
    py3  <= py2;
  end

  // clamp classes
  logic degen3, lo3, hi3;
  assign degen3 = len3 == '0;
  assign lo3    = dot3 <= 0;
  assign hi3    = dot3 >= $signed({1'b0, len3});

  logic              dv_valid;
  logic [F-1:0]      dv_quo;
  logic [SIDE_W-1:0] dv_side;

  psd_divider #(
    .LENW   (LENW),
    .QW     (F),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .in_rem    (dot3[LENW-1:0]),
    .in_den    (len3),
    .in_side   ({dx3, dy3, px3, py3, degen3, lo3, hi3}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  logic signed [DW-1:0] dxd, dyd, pxd, pyd;
  logic                 degd, lod, hid;
  assign {dxd, dyd, pxd, pyd, degd, lod, hid} = dv_side;

  // stage t: clamped parameter, magnitudes of the direction
  logic                 vt;
  logic [TW-1:0]        tt;
  logic [DW-1:0]        axt, ayt;
  logic                 nxt, nyt, degt;
  logic signed [DW-1:0] pxt, pyt;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else begin
      vt <= dv_valid;
    end
    priority if (degd || lod) begin
      tt <= '0;
    end else if (hid) begin
      tt <= TW'(1) << F;
    end else begin
      tt <= {1'b0, dv_quo};
    end
    nxt  <= dxd[DW-1];
    nyt  <= dyd[DW-1];
    axt  <= dxd[DW-1] ? DW'(-dxd) : DW'(dxd);
    ayt  <= dyd[DW-1] ? DW'(-dyd) : DW'(dyd);
    degt <= degd;
    pxt  <= pxd;
    pyt  <= pyd;
  end

  // stage m: scale direction by t
  logic                 vm;
  logic [MW-1:0]        mxm, mym;
  logic                 nxm, nym, degm;
  logic signed [DW-1:0] pxm, pym;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= vt;
    end
    mxm  <= MW'(axt) * MW'(tt);
    mym  <= MW'(ayt) * MW'(tt);
    nxm  <= nxt;
    nym  <= nyt;
    degm <= degt;
    pxm  <= pxt;
    pym  <= pyt;
  end

  // round to nearest, ties away from zero
  logic [MW:0]          rxw, ryw;
  logic [DW-1:0]        rx, ry;
  logic signed [OW-1:0] cx, cy;

  assign rxw = ({1'b0, mxm} + ((MW+1)'(1) << (F - 1))) >> F;
  assign ryw = ({1'b0, mym} + ((MW+1)'(1) << (F - 1))) >> F;
  assign rx  = rxw[DW-1:0];
  assign ry  = ryw[DW-1:0];
  assign cx  = nxm ? -$signed(OW'(rx)) : $signed(OW'(rx));
  assign cy  = nym ? -$signed(OW'(ry)) : $signed(OW'(ry));

  // stage o: offset from closest point
  logic                 vo, dego;
  logic signed [OW-1:0] oxo, oyo;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else begin
      vo <= vm;
    end
    oxo  <= OW'(pxm) - cx;
    oyo  <= OW'(pym) - cy;
    dego <= degm;
  end

  // stage q: squares
  logic                  vq, degq;
  logic signed [SQW-1:0] sxq, syq;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else begin
      vq <= vo;
    end
    sxq  <= SQW'(oxo) * SQW'(oxo);
    syq  <= SQW'(oyo) * SQW'(oyo);
    degq <= dego;
  end

  // stage s: sum and saturate
  logic [SUMW-1:0]  sum_q;
  logic [CW-1:0]    sum_ext;
  logic             vs, degs;
  logic [DSQ_W-1:0] dsq_s;

  assign sum_q   = SUMW'($unsigned(sxq)) + SUMW'($unsigned(syq));
  assign sum_ext = CW'(sum_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else begin
      vs <= vq;
    end
    dsq_s <= (sum_ext > CW'(DSQ_MAX)) ? DSQ_MAX : sum_ext[DSQ_W-1:0];
    degs  <= degq;
  end

  logic             sq_valid;
  logic [RES_W-1:0] sq_root;
  logic [DSQ_W:0]   sq_side;

  psd_sqrt #(
    .SIDE_W (DSQ_W + 1)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vs),
    .in_x      (dsq_s),
    .in_side   ({dsq_s, degs}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sq_valid;
    end
    dist_sqr   <= sq_side[DSQ_W:1];
    degenerate <= sq_side[0];
    dist_res   <= sq_root;
  end

endmodule

// ===== src/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// port level checks for the distance pipeline
// ----------------------------------------------------------------------------
module psd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      busy,
  input logic                      done,
  input logic [psd_pkg::DSQ_W-1:0] dist_sqr,
  input logic [psd_pkg::RES_W-1:0] dist_res
);
  import psd_pkg::*;

  logic [2*RES_W+1:0] res_sq;
  logic [2*RES_W+1:0] res1_sq;

  assign res_sq  = (2*RES_W+2)'(dist_res) * (2*RES_W+2)'(dist_res);
  assign res1_sq = ((2*RES_W+2)'(dist_res) + 1) * ((2*RES_W+2)'(dist_res) + 1);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_root_floor: assert property (@(posedge clk) disable iff (rst)
      done |-> (res_sq <= (2*RES_W+2)'(dist_sqr)) && (res1_sq > (2*RES_W+2)'(dist_sqr)))
    else $error("dist_res is not the floor root of dist_sqr");

  a_quiet_after_reset: assert property (@(posedge clk) $past(rst) |-> !done)
    else $error("word strobed right after reset");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .done     (done),
  .dist_sqr (dist_sqr),
  .dist_res (dist_res)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks point_segment_distance word by word against a local predictor
// ----------------------------------------------------------------------------
// Directed corner words come first, then random words, sent in phases of
// different idle density. Each accepted word is turned into an expected
// squared distance, root and degenerate flag. Each done strobe is then
// compared with the oldest expected result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = PARAM_FRAC_BITS_DEF;
  localparam int LATENCY = FB + 26;
  localparam longint LIMIT = 400000;

  typedef struct {
    logic [DSQ_W-1:0] dsq;
    logic [RES_W-1:0] root;
    logic             degen;
  } dist_t;

  // scoreboard: predicts results of accepted words, checks done words
  class dist_board;
    dist_t pending[$];
    int    errors;

    function longint round_scale(longint d, longint t);
      longint mag;
      longint r;
      mag = (d < 0 ? -d : d) * t;
      r = (mag + (64'sd1 <<< (FB - 1))) >>> FB;
      return d < 0 ? -r : r;
    endfunction

    function longint floor_root(longint v);
      longint r;
      longint b;
      r = 0;
      for (b = 64'sd1 <<< 20; b > 0; b = b >>> 1)
        if ((r + b) * (r + b) <= v) r = r + b;
      return r;
    endfunction

    function void note_word(logic signed [CB-1:0] sx, sy, ex, ey, qx, qy);
      longint dx, dy, px, py, len2, dot, t, rem, ox, oy, dsq;
      dist_t e;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      px = longint'(qx) - longint'(sx);
      py = longint'(qy) - longint'(sy);
      len2 = dx * dx + dy * dy;
      e.degen = (len2 == 0);
      if (len2 == 0) begin
        dsq = px * px + py * py;
      end else begin
        dot = px * dx + py * dy;
        if (dot <= 0) begin
          t = 0;
        end else if (dot >= len2) begin
          t = 64'sd1 <<< FB;
        end else begin
          // restoring division, one quotient bit per step
          rem = dot;
          t = 0;
          for (int i = 0; i < FB; i++) begin
            rem = rem <<< 1;
            t = t <<< 1;
            if (rem >= len2) begin
              rem = rem - len2;
              t = t | 1;
            end
          end
        end
        ox = px - round_scale(dx, t);
        oy = py - round_scale(dy, t);
        dsq = ox * ox + oy * oy;
      end
      if (dsq > longint'(DSQ_MAX)) dsq = longint'(DSQ_MAX);
      e.dsq = dsq[DSQ_W-1:0];
      e.root = RES_W'(floor_root(dsq));
      pending.push_back(e);
    endfunction

    function void check_word(logic [DSQ_W-1:0] dsq, logic [RES_W-1:0] root, logic degen);
      dist_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result dist_sqr=%0d", $time, dsq);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (dsq !== e.dsq) begin
        $display("%0t: dist_sqr expected %0d actual %0d", $time, e.dsq, dsq);
        errors++;
      end
      if (root !== e.root) begin
        $display("%0t: dist_res expected %0d actual %0d", $time, e.root, root);
        errors++;
      end
      if (degen !== e.degen) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.degen, degen);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy, done, degenerate;
  logic signed [CB-1:0] seg_start_x = 0, seg_start_y = 0, seg_end_x = 0;
  logic signed [CB-1:0] seg_end_y = 0, point_x = 0, point_y = 0;
  logic [DSQ_W-1:0] dist_sqr;
  logic [RES_W-1:0] dist_res;

  dist_board board = new();
  longint cycles = 0;
  int idle_pct = 0;

  always #1 clk = ~clk;

  point_segment_distance dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
    .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
    .point_x(point_x), .point_y(point_y),
    .done(done), .dist_sqr(dist_sqr), .dist_res(dist_res), .degenerate(degenerate)
  );

  // results cannot be held off, so every done cycle is taken as it comes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) board.check_word(dist_sqr, dist_res, degenerate);
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // hold one word on the ports until it is taken; start stays up between words unless an idle cycle is drawn
  task send_word(logic signed [CB-1:0] sx, sy, ex, ey, qx, qy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    seg_start_x <= sx; seg_start_y <= sy;
    seg_end_x <= ex; seg_end_y <= ey;
    point_x <= qx; point_y <= qy;
    do @(posedge clk); while (busy);
    board.note_word(sx, sy, ex, ey, qx, qy);
  endtask

  // wait at clock edges until every expected result has come back
  task drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // coordinates: near the base, small, near a corner or full range, each in one case of four
  function logic signed [CB-1:0] rand_coord(logic signed [CB-1:0] base);
    case ($urandom_range(3))
      0: return CB'(base + $signed(CB'($urandom_range(15))) - 8);
      1: return CB'($signed(CB'($urandom_range(255))) - 128);
      2: return $urandom_range(1) ? 16'sh7fff - CB'($urandom_range(3))
                                  : 16'sh8000 + CB'($urandom_range(3));
      default: return $signed(CB'($urandom));
    endcase
  endfunction

  task random_phase(int n, int pct);
    logic signed [CB-1:0] sx, sy;
    idle_pct = pct;
    repeat (n) begin
      sx = $signed(CB'($urandom));
      sy = rand_coord(sx);
      // one in eight words uses a zero-length segment
      if ($urandom_range(7) == 0) send_word(sx, sy, sx, sy, rand_coord(sx), rand_coord(sy));
      else send_word(sx, sy, rand_coord(sx), rand_coord(sy), rand_coord(sy), rand_coord(sx));
    end
  endtask

  localparam logic signed [CB-1:0] MAXC = 16'sh7fff, MINC = 16'sh8000;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, zero-length segments, clamps at both ends, interior
    send_word(0, 0, 0, 0, 0, 0);
    send_word(MAXC, MAXC, MAXC, MAXC, MINC, MINC);
    send_word(MINC, MINC, MINC, MINC, MAXC, MAXC);
    send_word(MINC, MAXC, MAXC, MINC, MAXC, MAXC);
    send_word(MINC, MINC, MAXC, MAXC, MINC, MAXC);
    send_word(0, 0, 160, 0, -80, 32);
    send_word(0, 0, 160, 0, 400, -32);
    send_word(0, 0, 160, 0, 80, 32);
    send_word(0, 0, 160, 0, 160, 0);
    send_word(0, 0, 3, 7, 5, -2);
    send_word(10, -10, -30, 50, 1, 1);
    send_word(MAXC, MAXC, MINC, MINC, 0, 0);
    send_word(MINC, 0, MAXC, 0, 0, MAXC);
    send_word(-1, -1, 1, 1, -1, 1);
    send_word(0, 0, 1, 0, 0, 0);
    send_word(0, 0, 0, -1, MAXC, MINC);
    send_word(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh5555, 16'sh5555);

    // sender pauses until every pending result is back
    start <= 0;
    drain();
    @(posedge clk);

    random_phase(350, 0);
    random_phase(250, 84);
    random_phase(300, 0);
    random_phase(350, 21);
    start <= 0;

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
